>>> rtl/clbp_pkg.sv
package clbp_pkg;

  localparam int unsigned MaxWidth = 1024;
  localparam int unsigned ColW     = $clog2(MaxWidth);
  localparam int unsigned PixW     = 8;
  localparam int unsigned WidthW   = 11;
  localparam int unsigned HeightW  = 16;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned RamDataW = 2 * PixW;

  localparam logic [WidthW-1:0]  WidthReset  = WidthW'(640);
  localparam logic [HeightW-1:0] HeightReset = HeightW'(480);

  typedef enum logic [0:0] {
    CfgFrameWidth  = 1'b0,
    CfgFrameHeight = 1'b1
  } cfg_index_e;

  // [row][col], row 0 is the oldest line, col 2 the newest pixel
  typedef logic [2:0][2:0][PixW-1:0] window_t;

  typedef struct packed {
    logic emit;
    logic row_last;
    logic frame_last;
  } item_meta_t;

endpackage

>>> rtl/circular_lbp_operator_top.sv
// channel   direction  handshake                 payload
// in        input      in_valid_i / in_ready_o   pixel_i[7:0]
// out       output     out_valid_o / out_ready_i pattern_code_o[7:0], row_end_o, frame_end_o
// cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i[15:0]
//
// One pixel per cycle sustained while the output is not stalled.
// Stages: line RAM read, window shift, code register. The line RAM has one read and
// one write port, so each pixel reads and writes back its column once.
// Border pixels produce no code and drain without needing the output.
// Reset sets counters to zero, window to zero, size to 640x480; line RAM is not cleared.
// An output stall backs up through the stages to in_ready_o.
module circular_lbp_operator_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [clbp_pkg::PixW-1:0]         pixel_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [clbp_pkg::PixW-1:0]         pattern_code_o,
  output logic                              row_end_o,
  output logic                              frame_end_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  clbp_pkg::cfg_index_e              cfg_index_i,
  input  logic [clbp_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam int unsigned ColW = clbp_pkg::ColW;
  localparam int unsigned PixW = clbp_pkg::PixW;

  logic [clbp_pkg::WidthW-1:0]  width_q;
  logic [clbp_pkg::HeightW-1:0] height_q;

  logic [ColW-1:0]              column_q, column_d;
  logic [clbp_pkg::HeightW-1:0] row_q, row_d;

  logic                         s1_valid_q;
  logic [PixW-1:0]              s1_px_q;
  logic [ColW-1:0]              s1_addr_q;
  clbp_pkg::item_meta_t         s1_meta_q;

  logic                         s2_valid_q;
  clbp_pkg::item_meta_t         s2_meta_q;
  clbp_pkg::window_t            window_q, window_d;

  logic                         out_valid_q;
  logic [PixW-1:0]              code_q;
  logic                         row_end_q, frame_end_q;

  logic [ColW:0]                w_eff;
  logic [ColW:0]                w_last_full;
  logic [ColW-1:0]              w_last;
  logic [clbp_pkg::HeightW-1:0] h_last;
  logic [ColW-1:0]              acc_col;
  clbp_pkg::item_meta_t         acc_meta;

  logic                         in_acc, out_free, s2_go, s2_free, s1_go;
  logic [clbp_pkg::RamDataW-1:0] rd_data;
  logic [PixW-1:0]              code;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= clbp_pkg::WidthReset;
      height_q <= clbp_pkg::HeightReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        clbp_pkg::CfgFrameWidth:  width_q  <= cfg_data_i[clbp_pkg::WidthW-1:0];
        clbp_pkg::CfgFrameHeight: height_q <= cfg_data_i[clbp_pkg::HeightW-1:0];
        default: ;
      endcase
    end
  end

  // effective frame size
  always_comb begin
    if (32'(width_q) > clbp_pkg::MaxWidth) begin
      w_eff = (ColW+1)'(clbp_pkg::MaxWidth);
    end else if (width_q < clbp_pkg::WidthW'(3)) begin
      w_eff = (ColW+1)'(3);
    end else begin
      w_eff = (ColW+1)'(width_q);
    end
    w_last_full = w_eff - (ColW+1)'(1);
    w_last      = w_last_full[ColW-1:0];
    if (height_q < clbp_pkg::HeightW'(3)) begin
      h_last = clbp_pkg::HeightW'(2);
    end else begin
      h_last = height_q - clbp_pkg::HeightW'(1);
    end
  end

  // position of the incoming item
  always_comb begin
    if ({1'b0, column_q} >= w_eff) begin
      acc_col = w_last;
    end else begin
      acc_col = column_q;
    end
    acc_meta.row_last   = (acc_col == w_last);
    acc_meta.frame_last = acc_meta.row_last && (row_q >= h_last);
    acc_meta.emit       = (row_q >= clbp_pkg::HeightW'(2)) && (acc_col >= ColW'(2));
  end

  // pipeline flow
  assign out_free   = !out_valid_q || out_ready_i;
  assign s2_go      = s2_valid_q && (!s2_meta_q.emit || out_free);
  assign s2_free    = !s2_valid_q || s2_go;
  assign s1_go      = s1_valid_q && s2_free;
  assign in_ready_o = !s1_valid_q || s1_go;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    column_d = column_q;
    row_d    = row_q;
    if (in_acc) begin
      if (acc_meta.row_last) begin
        column_d = '0;
        row_d    = acc_meta.frame_last ? '0 : row_q + clbp_pkg::HeightW'(1);
      end else begin
        column_d = acc_col + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q <= '0;
      row_q    <= '0;
    end else begin
      column_q <= column_d;
      row_q    <= row_d;
    end
  end

  // stage 1: line RAM read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_meta_q  <= '0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
      if (in_valid_i) begin
        s1_meta_q <= acc_meta;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_px_q   <= pixel_i;
      s1_addr_q <= acc_col;
    end
  end

  // word holds {older line, newer line}
  clbp_line_ram u_line_ram (
    .clk_i     (clk_i),
    .wr_en_i   (s1_go),
    .wr_addr_i (s1_addr_q),
    .wr_data_i ({rd_data[PixW-1:0], s1_px_q}),
    .rd_en_i   (in_acc),
    .rd_addr_i (acc_col),
    .rd_data_o (rd_data)
  );

  // stage 2: window shift
  always_comb begin
    window_d = window_q;
    for (int k = 0; k < 3; k++) begin
      window_d[k][0] = window_q[k][1];
      window_d[k][1] = window_q[k][2];
    end
    window_d[0][2] = rd_data[2*PixW-1:PixW];
    window_d[1][2] = rd_data[PixW-1:0];
    window_d[2][2] = s1_px_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s2_meta_q  <= '0;
      window_q   <= '0;
    end else if (s2_free) begin
      s2_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        s2_meta_q <= s1_meta_q;
        window_q  <= window_d;
      end
    end
  end

  clbp_code_calc u_code_calc (
    .window_i (window_q),
    .code_o   (code)
  );

  // stage 3: result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s2_valid_q && s2_meta_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s2_valid_q && s2_meta_q.emit) begin
      code_q      <= code;
      row_end_q   <= s2_meta_q.row_last;
      frame_end_q <= s2_meta_q.frame_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pattern_code_o = code_q;
  assign row_end_o      = row_end_q;
  assign frame_end_o    = frame_end_q;

  // checks
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s1_go) |-> (acc_col != s1_addr_q))
    else $error("line RAM read and write hit the same column");

  a_window_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !s2_go) |=> (s2_valid_q && $stable(window_q)))
    else $error("window changed under a waiting item");

  a_s1_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s2_free) |=> (s1_valid_q && $stable(s1_addr_q)))
    else $error("stage 1 item lost while stage 2 blocked");

  a_row_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && acc_meta.row_last) |=> (column_q == '0))
    else $error("column did not wrap at row end");

  a_frame_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && s2_meta_q.frame_last) |-> s2_meta_q.row_last)
    else $error("frame end without row end");

endmodule

>>> rtl/clbp_line_ram.sv
module clbp_line_ram (
  input  logic                              clk_i,
  input  logic                              wr_en_i,
  input  logic [clbp_pkg::ColW-1:0]         wr_addr_i,
  input  logic [clbp_pkg::RamDataW-1:0]     wr_data_i,
  input  logic                              rd_en_i,
  input  logic [clbp_pkg::ColW-1:0]         rd_addr_i,
  output logic [clbp_pkg::RamDataW-1:0]     rd_data_o
);

  logic [clbp_pkg::RamDataW-1:0] mem_q [clbp_pkg::MaxWidth];
  logic [clbp_pkg::RamDataW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/clbp_code_calc.sv
module clbp_code_calc (
  input  clbp_pkg::window_t             window_i,
  output logic [clbp_pkg::PixW-1:0]     code_o
);

  localparam logic [23:0] WCorner = 24'd32768;
  localparam logic [23:0] WSide   = 24'd13573;
  localparam logic [23:0] WCentre = 24'd5622;

  // weighted blend compared at 2^16 scale, max sum fits 24 bits
  function automatic logic diag_bit(input logic [7:0] corner, input logic [7:0] side_a,
                                    input logic [7:0] side_b, input logic [7:0] centre);
    logic [23:0] sum;
    logic [23:0] ref_val;
    sum = 24'(WCorner * corner) + 24'(WSide * ({1'b0, side_a} + {1'b0, side_b}))
        + 24'(WCentre * centre);
    ref_val = {centre, 16'd0};
    return sum >= ref_val;
  endfunction

  logic [7:0] ctr, rt, up, lt, dn;

  always_comb begin
    ctr = window_i[1][1];
    rt  = window_i[1][2];
    up  = window_i[0][1];
    lt  = window_i[1][0];
    dn  = window_i[2][1];
    code_o[0] = rt >= ctr;
    code_o[1] = diag_bit(window_i[0][2], up, rt, ctr);
    code_o[2] = up >= ctr;
    code_o[3] = diag_bit(window_i[0][0], up, lt, ctr);
    code_o[4] = lt >= ctr;
    code_o[5] = diag_bit(window_i[2][0], lt, dn, ctr);
    code_o[6] = dn >= ctr;
    code_o[7] = diag_bit(window_i[2][2], dn, rt, ctr);
  end

endmodule

>>> test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumRandomPixels = 600;
  localparam int unsigned StallLimit      = 2000;
  localparam int unsigned DrainCycles     = 8;
  localparam int unsigned WeightCorner    = 32768;
  localparam int unsigned WeightSide      = 13573;
  localparam int unsigned WeightCentre    = 5622;

  typedef struct packed {
    logic [clbp_pkg::PixW-1:0] code;
    logic                      row_end;
    logic                      frame_end;
  } lbp_result_t;

  typedef struct packed {
    logic [clbp_pkg::PixW-1:0] pixel;
    logic                      typed;
    lbp_result_t               result;
  } stim_row_t;

  // two 3x3 frames: flat black, then a white centre on black
  localparam stim_row_t Directed [18] = '{
    '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b1, '{8'hFF, 1'b1, 1'b1}},
    '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b1, '{8'h00, 1'b1, 1'b1}}
  };

  logic                          clk_i          = 1'b0;
  logic                          rst_ni         = 1'b0;
  logic                          in_valid_i     = 1'b0;
  logic                          in_ready_o;
  logic [clbp_pkg::PixW-1:0]     pixel_i        = '0;
  logic                          out_valid_o;
  logic                          out_ready_i    = 1'b0;
  logic [clbp_pkg::PixW-1:0]     pattern_code_o;
  logic                          row_end_o;
  logic                          frame_end_o;
  logic                          cfg_valid_i    = 1'b0;
  logic                          cfg_ready_o;
  clbp_pkg::cfg_index_e          cfg_index_i    = clbp_pkg::CfgFrameWidth;
  logic [clbp_pkg::CfgDataW-1:0] cfg_data_i     = '0;

  circular_lbp_operator_top i_dut (.*);

  // predictor state
  logic [clbp_pkg::PixW-1:0]    line_old [clbp_pkg::MaxWidth];
  logic [clbp_pkg::PixW-1:0]    line_new [clbp_pkg::MaxWidth];
  logic [clbp_pkg::PixW-1:0]    win [3][3];
  int unsigned                  col_pos;
  int unsigned                  row_pos;
  logic [clbp_pkg::WidthW-1:0]  width_reg;
  logic [clbp_pkg::HeightW-1:0] height_reg;

  lbp_result_t pending_codes [$];
  int unsigned gap_max   = 0;
  int unsigned stall_max = 0;
  bit          failed    = 1'b0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned active_width();
    if (width_reg < 3) return 3;
    if (width_reg > clbp_pkg::MaxWidth) return clbp_pkg::MaxWidth;
    return width_reg;
  endfunction

  function automatic int unsigned active_height();
    return (height_reg < 3) ? 3 : height_reg;
  endfunction

  function automatic bit diag_set(int unsigned corner, int unsigned side_a,
                                  int unsigned side_b, int unsigned centre);
    return WeightCorner * corner + WeightSide * (side_a + side_b)
           + WeightCentre * centre >= (centre << 16);
  endfunction

  // advances the window by one pixel; returns 1 when an interior code is due
  function automatic bit lbp_step(input logic [clbp_pkg::PixW-1:0] px,
                                  output lbp_result_t res);
    int unsigned w, h, c, r, ctr, k;
    logic [clbp_pkg::PixW-1:0] top, mid;
    bit row_last, frame_last;
    w = active_width();
    h = active_height();
    c = (col_pos >= w) ? w - 1 : col_pos;
    r = row_pos;
    top = line_old[c];
    mid = line_new[c];
    line_old[c] = mid;
    line_new[c] = px;
    for (k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = px;
    row_last = c >= w - 1;
    frame_last = row_last && r >= h - 1;
    if (row_last) begin
      col_pos = 0;
      row_pos = frame_last ? 0 : (r + 1) & 32'hFFFF;
    end else begin
      col_pos = c + 1;
    end
    ctr = win[1][1];
    res.code = {diag_set(win[2][2], win[2][1], win[1][2], ctr), win[2][1] >= ctr,
                diag_set(win[2][0], win[1][0], win[2][1], ctr), win[1][0] >= ctr,
                diag_set(win[0][0], win[0][1], win[1][0], ctr), win[0][1] >= ctr,
                diag_set(win[0][2], win[0][1], win[1][2], ctr), win[1][2] >= ctr};
    res.row_end = row_last;
    res.frame_end = frame_last;
    return r >= 2 && c >= 2;
  endfunction

  // leaves cfg_valid_i high; the caller drops it after the last write
  task automatic write_reg(input clbp_pkg::cfg_index_e idx,
                           input logic [clbp_pkg::CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      clbp_pkg::CfgFrameWidth:  width_reg = data[clbp_pkg::WidthW-1:0];
      clbp_pkg::CfgFrameHeight: height_reg = data[clbp_pkg::HeightW-1:0];
      default: ;
    endcase
  endtask

  task automatic send_pixel(input logic [clbp_pkg::PixW-1:0] px, input bit typed,
                            input lbp_result_t typed_res);
    int unsigned gap;
    lbp_result_t res;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_i    <= px;
    do @(posedge clk_i); while (!in_ready_o);
    if (lbp_step(px, res)) pending_codes.push_back(typed ? typed_res : res);
  endtask

  // border pixels drain without a code, so keep clocking for DrainCycles after the last expected code
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin : result_sink
    int unsigned stall;
    lbp_result_t want;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, stall_max);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      if (pending_codes.size() == 0) begin
        $display("%0t: unexpected item, expected none got code %02h",
                 $time, pattern_code_o);
        failed = 1'b1;
      end else begin
        want = pending_codes.pop_front();
        if (pattern_code_o !== want.code) begin
          $display("%0t: pattern_code expected %02h got %02h",
                   $time, want.code, pattern_code_o);
          failed = 1'b1;
        end
        if (row_end_o !== want.row_end) begin
          $display("%0t: row_end expected %0b got %0b", $time, want.row_end, row_end_o);
          failed = 1'b1;
        end
        if (frame_end_o !== want.frame_end) begin
          $display("%0t: frame_end expected %0b got %0b",
                   $time, want.frame_end, frame_end_o);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= StallLimit) begin
        $display("%0t: no progress for %0d cycles", $time, quiet);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned sent, phase, count, w, h;
    bit wide_done, tall_done, wide_phase;
    logic [clbp_pkg::PixW-1:0] base, px;

    foreach (line_old[i]) begin
      line_old[i] = '0;
      line_new[i] = '0;
    end
    foreach (win[i, j]) win[i][j] = '0;
    col_pos    = 0;
    row_pos    = 0;
    width_reg  = clbp_pkg::WidthReset;
    height_reg = clbp_pkg::HeightReset;
    sent       = 0;
    phase      = 0;
    wide_done  = 1'b0;
    tall_done  = 1'b0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // out-of-range sizes clamp to 3x3
    gap_max   = 15;
    stall_max = 15;
    write_reg(clbp_pkg::CfgFrameWidth, 16'd0);
    write_reg(clbp_pkg::CfgFrameHeight, 16'd2);
    cfg_valid_i <= 1'b0;
    foreach (Directed[i]) send_pixel(Directed[i].pixel, Directed[i].typed, Directed[i].result);
    settle();

    while (sent < NumRandomPixels || !tall_done) begin
      gap_max    = ($urandom_range(0, 3) == 0) ? 0 : 15;
      stall_max  = ($urandom_range(0, 3) == 0) ? 0 : 15;
      wide_phase = 1'b0;
      if (col_pos == 0 && row_pos == 0) begin
        if (!wide_done && phase >= 2) begin
          write_reg(clbp_pkg::CfgFrameWidth, {5'($urandom), 11'h7FF});
          write_reg(clbp_pkg::CfgFrameHeight, 16'd0);
          wide_done  = 1'b1;
          wide_phase = 1'b1;
        end else begin
          if ($urandom_range(0, 3) != 0) begin
            write_reg(clbp_pkg::CfgFrameWidth, {5'($urandom), (($urandom_range(0, 7) == 0) ?
                      11'($urandom_range(0, 2)) : 11'($urandom_range(3, 12)))});
          end
          if (!tall_done && phase >= 4) begin
            write_reg(clbp_pkg::CfgFrameHeight, 16'hFFFF);
            tall_done = 1'b1;
          end else if ($urandom_range(0, 3) != 0) begin
            write_reg(clbp_pkg::CfgFrameHeight, ($urandom_range(0, 7) == 0) ?
                      16'($urandom_range(0, 2)) : 16'($urandom_range(3, 6)));
          end
        end
      end else begin
        // mid-frame: height may move either way, width only shrinks
        if (active_height() > 64 || $urandom_range(0, 2) == 0) begin
          write_reg(clbp_pkg::CfgFrameHeight, 16'($urandom_range(0, 8)));
        end else if ($urandom_range(0, 1) == 0) begin
          write_reg(clbp_pkg::CfgFrameWidth,
                    {5'($urandom), 11'($urandom_range(0, active_width()))});
        end
      end
      cfg_valid_i <= 1'b0;

      w = active_width();
      h = active_height();
      count = ((row_pos >= h - 1) ? 1 : h - row_pos) * w - ((col_pos >= w) ? w - 1 : col_pos);
      if (count > 4096) begin
        count = 4 * w + $urandom_range(0, w - 1);
      end else if (!wide_phase && count > 1 && $urandom_range(0, 3) == 0) begin
        count = $urandom_range(1, count - 1);
      end

      base = 8'($urandom);
      repeat (count) begin
        case ($urandom_range(0, 3))
          0:       px = base + 8'($urandom_range(0, 2)) - 8'd1;
          1:       px = {clbp_pkg::PixW{$urandom_range(0, 1) == 1}};
          default: px = 8'($urandom);
        endcase
        send_pixel(px, 1'b0, '0);
        if (!wide_phase) sent++;
      end
      settle();
      phase++;
    end

    if (!failed) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
